[sv/binary_to_decimal_ascii_macros.svh]
// Assertion macros of the binary to decimal ASCII converter, used by its converter stage.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B2DA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b2da: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b2da: next-cycle check failed");

`endif

[sv/b2da_pkg.sv]
// Shared types and constants of the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;
    localparam int Q_DEPTH = 2;

    // Decimal digit count of 2^n - 1 is ((n * DIG_MUL) >> DIG_SHIFT) + 1.
    localparam int DIG_MUL   = 1233;
    localparam int DIG_SHIFT = 12;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DD_LIMIT   = 4'd5;
    localparam logic [DIGIT_W-1:0] DD_ADJUST  = 4'd3;

    typedef logic [VALUE_W-1:0] t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[sv/b2da_front.sv]
// Input stage: takes beats, masks the value and hands it to the queue.
module b2da_front #(
    parameter int CONV_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_value,
    input  b2da_pkg::t_q_status i_q_stat,
    output logic               o_push,
    output b2da_pkg::t_item    o_item
);

    localparam logic [b2da_pkg::VALUE_W-1:0] MASK =
        b2da_pkg::VALUE_W'((64'd1 << CONV_BITS) - 64'd1);

    logic            r_vld;
    logic            n_vld;
    b2da_pkg::t_item r_val;
    logic            accept;

    assign o_stall = r_vld && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_q_stat.full;
    assign o_item  = r_val;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= i_value & MASK;
        end
    end

endmodule

[sv/b2da_queue.sv]
// Two-entry queue that decouples the input stage from the converter.
module b2da_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b2da_pkg::t_item     i_item,
    input  logic                i_pop,
    output b2da_pkg::t_item     o_item,
    output b2da_pkg::t_q_status o_stat
);

    localparam int PTR_W = $clog2(b2da_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(b2da_pkg::Q_DEPTH + 1);

    b2da_pkg::t_item r_entry [b2da_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_item       = r_entry[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(b2da_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/b2da_back.sv]
// Converter: double-dabble over the value bits, then digit emission without leading zeros.
`include "binary_to_decimal_ascii_macros.svh"
module b2da_back #(
    parameter int CONV_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  b2da_pkg::t_item             i_item,
    input  b2da_pkg::t_q_status         i_q_stat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [b2da_pkg::CHAR_W-1:0] o_digit_char,
    output logic                        o_last_digit
);

    localparam int NUM_DIGITS =
        ((CONV_BITS * b2da_pkg::DIG_MUL) >> b2da_pkg::DIG_SHIFT) + 1;
    localparam int BCD_W = NUM_DIGITS * b2da_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(CONV_BITS);
    localparam int IDX_W = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    t_state                        r_state;
    logic [CONV_BITS-1:0]          r_bin;
    logic [BCD_W-1:0]              r_bcd;
    logic [CNT_W-1:0]              r_cnt;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_seen;
    logic                          r_ovld;
    logic [b2da_pkg::CHAR_W-1:0]   r_char;
    logic                          r_last;

    logic [BCD_W-1:0]              adj_bcd;
    logic [BCD_W-1:0]              n_bcd;
    logic [b2da_pkg::DIGIT_W-1:0]  cur_digit;
    logic                          emit;
    logic                          slot_free;
    logic                          load_beat;
    logic                          shift_done;
    logic                          shift_first;

    // One double-dabble step: correct every digit, then shift in the next bit.
    always_comb begin
        adj_bcd = r_bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DD_LIMIT) begin
                adj_bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    r_bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DD_ADJUST;
            end
        end
        n_bcd = {adj_bcd[BCD_W-2:0], r_bin[CONV_BITS-1]};
    end

    assign cur_digit = r_bcd[r_idx*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
    assign emit      = r_seen || (cur_digit != '0) || (r_idx == '0);
    assign slot_free = !r_ovld || !i_stall;
    assign load_beat = (r_state == ST_EMIT) && emit && slot_free;
    assign o_pop     = (r_state == ST_IDLE) && !i_q_stat.empty;

    assign shift_done  = (r_state == ST_SHIFT) && (r_cnt == '0);
    assign shift_first = (r_state == ST_SHIFT) && (r_cnt == CNT_W'(CONV_BITS - 1));

    assign o_valid      = r_ovld;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            if (load_beat) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && !i_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_bin   <= i_item[CONV_BITS-1:0];
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(CONV_BITS - 1);
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_bcd <= n_bcd;
                    r_bin <= {r_bin[CONV_BITS-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_idx   <= IDX_W'(NUM_DIGITS - 1);
                        r_seen  <= 1'b0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!emit) begin
                        r_idx <= r_idx - 1'b1;
                    end else if (slot_free) begin
                        r_char <= b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
                        r_last <= (r_idx == '0);
                        r_seen <= 1'b1;
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `B2DA_ASSERT_IMPLY(a_pop_not_empty, i_clk, i_rst_n, o_pop, !i_q_stat.empty)
    `B2DA_ASSERT_NEXT(a_shift_to_emit, i_clk, i_rst_n, shift_done, r_state == ST_EMIT)
    `B2DA_ASSERT_NEXT(a_pop_starts_shift, i_clk, i_rst_n, o_pop, shift_first)

endmodule

[sv/binary_to_decimal_ascii.sv]
// Top level of the binary to decimal ASCII converter.
// Usage: each input beat on i_valid/o_stall carries an unsigned binary value in
// i_value; only its low VALUE_BITS bits (at most 32) are converted. For every value
// the block sends a run of output beats on o_valid/i_stall, one per decimal digit,
// most significant digit first, as ASCII '0' to '9' in o_digit_char. Leading zeros
// are suppressed, and a value of zero gives a single '0'. o_last_digit marks the
// final beat of each run.
// Flow: a value passes through the input register and the two-entry queue, then the
// double-dabble shifter, one step per value bit, and then a scan of its decimal
// positions (D, ten for 32 bits), most significant first. The shared shifter and its
// digit scan convert one value at a time: the next value is popped from the queue only
// after the last digit beat of the current one has been loaded.
// Stalls: while i_stall is high the current digit beat holds and the scan waits at
// the next digit to send; the queue and input register still take up to three
// further values before o_stall rises.
// Reset: i_rst_n is synchronous and active low; it empties the queue and drops any
// run in progress. Nothing is kept from one value to the next.
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [31:0]                 i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [b2da_pkg::CHAR_W-1:0] o_digit_char,
    output logic                        o_last_digit
);

    // Bits actually converted: the value port is never wider than 32 bits.
    localparam int CONV_BITS =
        (VALUE_BITS < b2da_pkg::VALUE_W) ? VALUE_BITS : b2da_pkg::VALUE_W;

    b2da_pkg::t_q_status q_stat;
    b2da_pkg::t_item     push_item;
    b2da_pkg::t_item     pop_item;
    logic                push;
    logic                pop;

    // Front part: input register and masking.
    b2da_front #(
        .CONV_BITS (CONV_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_item   (push_item)
    );

    // The queue lets the front keep taking beats while a conversion runs.
    b2da_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    // Back part: double-dabble conversion and digit emission.
    b2da_back #(
        .CONV_BITS (CONV_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (pop_item),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

[test/tb_binary_to_decimal_ascii.sv]
// Self-checking testbench for the binary to decimal ASCII converter.
module tb_binary_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default width. The mask below follows that width,
    // so the prediction still holds if the parameter is narrowed.
    localparam int          VALUE_BITS  = 32;
    localparam logic [31:0] VALUE_MASK  = (VALUE_BITS >= 32) ? '1 : ((32'd1 << VALUE_BITS) - 1);
    localparam int          RADIX       = 10;
    localparam int          MAX_DIGITS  = 10;
    localparam int          IDLE_PCT    = 37;
    localparam int          RAND_VALUES = 400;
    localparam int          TAIL_CYCLES = 2 * VALUE_BITS + 40;
    // The limit leaves a wide margin over a correct run, even with every digit
    // waiting out the receiver's stalls and the longest sender gaps.
    localparam int          CYCLE_LIMIT = 200_000;

    // One digit beat as it should appear on the output channel.
    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } t_digit_beat;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic [31:0]                 i_value = '0;
    logic                        i_stall = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [b2da_pkg::CHAR_W-1:0] o_digit_char;
    logic                        o_last_digit;

    // Digit beats still owed by the block, oldest first.
    t_digit_beat pending_digits[$];

    // Throttle switches: when cleared, that side of the block runs flat out.
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;

    int failures     = 0;
    int cycles       = 0;
    int values_sent  = 0;
    int digits_seen  = 0;
    int runs_seen    = 0;

    binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_digit_char(o_digit_char),
        .o_last_digit(o_last_digit)
    );

    always #5 i_clk = ~i_clk;

    // Directed values. Where the decimal text is given it is the expected run itself;
    // an empty text means the run is left to the predictor. The list covers zero, the
    // single-digit and two-digit edges, each side of the sign bit, the largest value
    // and the ten-digit boundary.
    localparam int N_DIRECTED = 21;
    logic [31:0] directed_values [N_DIRECTED] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd255, 32'd256,
        32'd65535, 32'd65536, 32'd12345, 32'd999999999, 32'd1000000000,
        32'd1234567890, 32'd2147483647, 32'd2147483648, 32'h5555_5555,
        32'hAAAA_AAAA, 32'd4000000000, 32'd4294967294, 32'd4294967295
    };
    string directed_texts [N_DIRECTED] = '{
        "0", "1", "9", "10", "99", "100", "255", "",
        "65535", "", "", "999999999", "1000000000",
        "1234567890", "2147483647", "2147483648", "",
        "", "4000000000", "4294967294", "4294967295"
    };

    // Works out the decimal run of one value: digits are peeled off least
    // significant first, then queued most significant first. Zero still gives a
    // single '0', and the final digit carries the end-of-run mark.
    task automatic queue_decimal_digits(input logic [31:0] value);
        logic [3:0]  digs [MAX_DIGITS];
        logic [31:0] rest;
        int          count;
        t_digit_beat beat;
        rest  = value & VALUE_MASK;
        count = 0;
        do begin
            digs[count] = 4'(rest % RADIX);
            rest        = rest / RADIX;
            count++;
        end while (rest != 0 && count < MAX_DIGITS);
        for (int k = 0; k < count; k++) begin
            beat.digit_char = b2da_pkg::ASCII_ZERO + {2'b00, digs[count - 1 - k]};
            beat.last_digit = (k == count - 1);
            pending_digits.push_back(beat);
        end
    endtask

    // Queues a run typed in as decimal text.
    task automatic queue_typed_digits(input string text);
        t_digit_beat beat;
        byte         ch;
        for (int k = 0; k < text.len(); k++) begin
            ch              = text.getc(k);
            beat.digit_char = ch[b2da_pkg::CHAR_W-1:0];
            beat.last_digit = (k == text.len() - 1);
            pending_digits.push_back(beat);
        end
    endtask

    // Offers one value on the input channel and returns once the beat has been taken.
    // Random idle cycles may come first. Valid stays high from one beat to the next
    // when there is no gap, so it is never lowered and raised within one step.
    task automatic send_value(input logic [31:0] value, input string text);
        while (sender_gaps && $urandom_range(99, 0) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        // The beat was taken at this edge: record what it must produce.
        if (text.len() != 0) queue_typed_digits(text);
        else queue_decimal_digits(value);
        values_sent++;
    endtask

    // Draws a value with a spread of lengths: short values, full-width words, and
    // values close to a power of ten, where the digit count changes.
    function automatic logic [31:0] pick_value();
        logic [31:0] pow10;
        pow10 = 32'd1;
        case ($urandom_range(3, 0))
            0: return $urandom >> $urandom_range(31, 0);
            1: return $urandom;
            2: begin
                repeat ($urandom_range(MAX_DIGITS - 1, 0)) pow10 = pow10 * RADIX;
                return pow10 + $urandom_range(2, 0) - 1;
            end
            default: return $urandom_range(9999, 0);
        endcase
    endfunction

    // Receiver side: stalls at random, or never while its throttle is off.
    always @(posedge i_clk) begin
        i_stall <= receiver_gaps && ($urandom_range(99, 0) < IDLE_PCT);
    end

    // Every digit beat taken from the block is compared with the oldest one owed.
    always @(posedge i_clk) begin
        t_digit_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            digits_seen++;
            if (o_last_digit) runs_seen++;
            if (pending_digits.size() == 0) begin
                $display("%0t: digit beat %0d (last %0b) arrived with none expected",
                         $time, o_digit_char, o_last_digit);
                failures++;
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_char !== want.digit_char) begin
                    $display("%0t: digit_char expected %0d, got %0d",
                             $time, want.digit_char, o_digit_char);
                    failures++;
                end
                if (o_last_digit !== want.last_digit) begin
                    $display("%0t: last_digit expected %0b, got %0b",
                             $time, want.last_digit, o_last_digit);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d digit beats outstanding",
                     $time, pending_digits.size());
            $display("binary_to_decimal_ascii regression: fail");
            $finish;
        end
    end

    initial begin
        // Reset is held at the start and then released for good.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed values first.
        for (int n = 0; n < N_DIRECTED; n++) begin
            send_value(directed_values[n], directed_texts[n]);
        end

        // Random values in three stretches: throttled, then flat out on both sides,
        // then throttled again after the sender has waited for the block to drain.
        for (int n = 0; n < RAND_VALUES; n++) begin
            if (n == RAND_VALUES / 3) begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            if (n == 2 * RAND_VALUES / 3) begin
                sender_gaps   = 1'b1;
                receiver_gaps = 1'b1;
                // Hold the input off until every owed digit has come out.
                i_valid <= 1'b0;
                while (pending_digits.size() != 0) @(posedge i_clk);
            end
            send_value(pick_value(), "");
        end

        // Wind down: stop offering, let every run finish, then watch for stray beats.
        i_valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d values (%0d directed) into %0d digit beats over %0d runs,",
                 values_sent, N_DIRECTED, digits_seen, runs_seen);
        $display("with random gaps on both channels, a flat-out stretch and a full drain.");
        if (failures == 0) begin
            $display("binary_to_decimal_ascii regression: pass");
        end else begin
            $display("binary_to_decimal_ascii regression: fail");
        end
        $finish;
    end

endmodule
